// ===== rtl/cpst_pkg.sv =====
// shared types, constants and prefix helpers for the cidr prefix set table
// no dependencies; used by every module of the block but cpst_ram
package cpst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 128;
  localparam int HALF_W      = 64;
  localparam int LEN_W       = 8;
  localparam int ENTRY_W     = ADDR_W + LEN_W;
  localparam int SUM_W       = (CNT_W > LEN_W ? CNT_W : LEN_W) + 1;

  localparam logic [LEN_W-1:0] V4_OFFSET = 8'd96;
  localparam logic [LEN_W-1:0] V4_MAXLEN = 8'd32;
  localparam logic [LEN_W-1:0] V6_MAXLEN = 8'd128;

  // operation codes
  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_CONTAINS  = 3'd2;
  localparam logic [2:0] OP_INTERSECT = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  // status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_COVERED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_HIT      = 3'd5;
  localparam logic [2:0] ST_MISS     = 3'd6;
  localparam logic [2:0] ST_READ     = 3'd7;

  // what follows the scan pass
  typedef enum logic [1:0] {
    DEC_FINISH,
    DEC_MERGE,
    DEC_COPY
  } dec_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic decide;
    logic merge_step;
    logic copy_end;
    logic write_new;
    logic take;
    logic split_init;
    logic split_up;
    logic split_dn;
    logic read_latch;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_read;
    logic ptr_end;
    dec_t dec;
    logic merge_go;
    logic ev_split;
    logic ev_ins_first;
    logic up_end;
    logic dn_end;
  } stat_t;

  // top len bits set
  function automatic logic [ADDR_W-1:0] pfx_mask(input logic [LEN_W-1:0] len);
    pfx_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

  // last bit inside a prefix of length len (1..128)
  function automatic logic [ADDR_W-1:0] pfx_bit(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] top;
    top = {1'b1, {(ADDR_W-1){1'b0}}};
    pfx_bit = top >> LEN_W'(len - 8'd1);
  endfunction

endpackage

// ===== rtl/cidr_prefix_set_table_unit.sv =====
// top level of the cidr prefix set table: controller plus datapath
// depends on cpst_pkg, cpst_ctrl, cpst_dp, cpst_ram
//
// channel   handshake              payload
// command   start / busy           operation, address_high, address_low,
//                                  prefix_length, entry_index
// result    done (one-cycle)       status, found_index, entry_count, read_*
// config    cfg_valid / cfg_ready  cfg_data (address_family)
//
// an operation scans the table once and decides in a separate decide step;
// add then folds sibling pairs into their parent, and add or remove rebuild
// the table into the other bank, reading then copying each kept entry, stepping
// through the split levels up and down, writing a new entry and finishing;
// read instead fetches the indexed entry and latches it
// reset empties the table and selects IPv4; a family write also empties it
// results cannot be held off: done marks them for exactly one cycle
module cidr_prefix_set_table_unit import cpst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [63:0] address_high,
  input  logic [63:0] address_low,
  input  logic [7:0]  prefix_length,
  input  logic [7:0]  entry_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  found_index,
  output logic [8:0]  entry_count,
  output logic [63:0] read_address_high,
  output logic [63:0] read_address_low,
  output logic [7:0]  read_prefix_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // config waits while a command is running or being accepted
  assign cfg_ready = !busy && !start;

  cpst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd),
    .busy(busy), .done(done)
  );

  cpst_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_valid & cfg_ready), .cfg_data(cfg_data),
    .operation(operation), .address_high(address_high),
    .address_low(address_low), .prefix_length(prefix_length),
    .entry_index(entry_index), .status(status), .found_index(found_index),
    .entry_count(entry_count), .read_address_high(read_address_high),
    .read_address_low(read_address_low), .read_prefix_length(read_prefix_length)
  );

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 9'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/cpst_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module cpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cpst_ctrl.sv =====
// sequencer for the prefix table: scan, merge, copy, split and read steps
// depends on cpst_pkg
module cpst_ctrl import cpst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE,
    S_COPY_RD,
    S_COPY_EV,
    S_SPLIT_UP,
    S_SPLIT_DN,
    S_READ_A,
    S_READ_B
  } state_t;

  state_t state, state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = st.req_read ? S_READ_A : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.ptr_end) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        case (st.dec)
          DEC_MERGE: state_next = S_MERGE;
          DEC_COPY:  state_next = S_COPY_RD;
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_MERGE: begin
        if (st.merge_go) cmd.merge_step = 1'b1;
        else state_next = S_COPY_RD;
      end
      S_COPY_RD: begin
        if (st.ptr_end) begin
          cmd.copy_end = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_COPY_EV;
        end
      end
      S_COPY_EV: begin
        if (st.ev_split) begin
          cmd.split_init = 1'b1;
          state_next     = S_SPLIT_UP;
        end else if (st.ev_ins_first) begin
          cmd.write_new = 1'b1;
        end else begin
          cmd.take   = 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_SPLIT_UP: begin
        cmd.split_up = 1'b1;
        if (st.up_end) state_next = S_SPLIT_DN;
      end
      S_SPLIT_DN: begin
        cmd.split_dn = 1'b1;
        if (st.dn_end) state_next = S_COPY_RD;
      end
      S_READ_A: state_next = S_READ_B;
      S_READ_B: begin
        cmd.read_latch = 1'b1;
        done_next      = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// ===== rtl/cpst_dp.sv =====
// datapath: two table banks, scan results, copy and split writers, results
// depends on cpst_pkg and cpst_ram
module cpst_dp import cpst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic [2:0]         operation,
  input  logic [HALF_W-1:0]  address_high,
  input  logic [HALF_W-1:0]  address_low,
  input  logic [LEN_W-1:0]   prefix_length,
  input  logic [7:0]         entry_index,
  output logic [2:0]         status,
  output logic [7:0]         found_index,
  output logic [8:0]         entry_count,
  output logic [HALF_W-1:0]  read_address_high,
  output logic [HALF_W-1:0]  read_address_low,
  output logic [LEN_W-1:0]   read_prefix_length
);

  // control state
  logic             fam, bank;
  logic [CNT_W-1:0] count, ptr, wr_ptr;
  logic             s_valid, ins;
  // request
  logic [2:0]        req_op;
  logic [ADDR_W-1:0] req_a;
  logic [LEN_W-1:0]  req_l, off, f, k;
  logic [7:0]        req_idx;
  // scan results
  logic              cov, any_in, c_found, hit;
  logic [IDX_W-1:0]  c_idx, hit_idx, s_idx;
  logic [LEN_W-1:0]  m;
  logic [ADDR_W:0]   sib;
  // results
  logic [2:0]        res_status;
  logic [7:0]        res_found;
  logic [ENTRY_W-1:0] rd_entry;

  // input normalization
  logic [LEN_W-1:0]  in_max, in_l, in_off, in_len;
  logic [ADDR_W-1:0] in_a;
  always_comb begin
    in_max = fam ? V6_MAXLEN : V4_MAXLEN;
    in_l   = (prefix_length > in_max) ? in_max : prefix_length;
    in_off = fam ? '0 : V4_OFFSET;
    in_len = in_l + in_off;
    in_a   = fam ? {address_high, address_low} : {96'd0, address_low[31:0]};
    in_a   = in_a & pfx_mask(in_len);
  end

  // table banks: read from bank, write to the other
  logic               we;
  logic [ENTRY_W-1:0] wdata, rdata0, rdata1, rdata;

  cpst_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk(clk), .we(we & bank), .waddr(wr_ptr[IDX_W-1:0]), .wdata(wdata),
    .raddr(ptr[IDX_W-1:0]), .rdata(rdata0)
  );
  cpst_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram1 (
    .clk(clk), .we(we & ~bank), .waddr(wr_ptr[IDX_W-1:0]), .wdata(wdata),
    .raddr(ptr[IDX_W-1:0]), .rdata(rdata1)
  );
  assign rdata = bank ? rdata1 : rdata0;

  // entry under test
  logic [ADDR_W-1:0] e_a;
  logic [LEN_W-1:0]  e_l;
  logic              e_cov, e_in, e_sib, e_hit;
  always_comb begin
    e_a   = rdata[ENTRY_W-1:LEN_W];
    e_l   = rdata[LEN_W-1:0] + off;
    e_cov = (e_l <= req_l) && ((req_a & pfx_mask(e_l)) == e_a);
    e_in  = (e_l >= req_l) && ((e_a & pfx_mask(req_l)) == req_a);
    e_sib = (e_l > off) && (e_l <= req_l) &&
            (((e_a ^ req_a) & pfx_mask(e_l)) == pfx_bit(e_l));
    e_hit = e_cov || ((req_op == OP_INTERSECT) && e_in);
  end

  // decision after the scan
  logic       split;
  dec_t       dec;
  logic [2:0] dec_status;
  logic [SUM_W-1:0] split_need;
  always_comb begin
    split      = (req_op == OP_REMOVE) && c_found && (m < req_l);
    split_need = SUM_W'(count) + SUM_W'(req_l) - SUM_W'(m) - SUM_W'(1);
    dec        = DEC_FINISH;
    dec_status = ST_MISS;
    case (req_op)
      OP_ADD: begin
        if (cov) begin
          dec_status = ST_COVERED;
        end else if (!any_in && (count == CNT_W'(TABLE_DEPTH)) &&
                     ((req_l <= off) || !sib[req_l])) begin
          dec_status = ST_FULL;
        end else begin
          dec        = DEC_MERGE;
          dec_status = ST_INSERTED;
        end
      end
      OP_REMOVE: begin
        if (split) begin
          if (split_need > SUM_W'(TABLE_DEPTH)) begin
            dec_status = ST_FULL;
          end else begin
            dec        = DEC_COPY;
            dec_status = ST_REMOVED;
          end
        end else if (any_in) begin
          dec        = DEC_COPY;
          dec_status = ST_REMOVED;
        end else begin
          dec_status = ST_NONE;
        end
      end
      OP_CONTAINS, OP_INTERSECT: dec_status = hit ? ST_HIT : ST_MISS;
      default: dec_status = ST_MISS;
    endcase
  end

  // copy pass: reference prefix is the request merged down to length f
  logic [ADDR_W-1:0]  rp, sp;
  logic               ev_drop, a_k, is_add;
  logic [ENTRY_W-1:0] new_entry, split_entry;
  always_comb begin
    is_add      = (req_op == OP_ADD);
    rp          = req_a & pfx_mask(f);
    ev_drop     = !split && (e_l >= f) && ((e_a & pfx_mask(f)) == rp);
    new_entry   = {rp, LEN_W'(f - off)};
    a_k         = |(req_a & pfx_bit(k));
    sp          = (req_a & pfx_mask(k)) ^ pfx_bit(k);
    split_entry = {sp, LEN_W'(k - off)};
  end

  // table write port
  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (cmd.write_new) begin
      we    = 1'b1;
      wdata = new_entry;
    end else if (cmd.take) begin
      we = !ev_drop;
    end else if (cmd.split_up) begin
      we    = a_k;
      wdata = split_entry;
    end else if (cmd.split_dn) begin
      we    = !a_k;
      wdata = split_entry;
    end else if (cmd.copy_end) begin
      we    = is_add && !ins;
      wdata = new_entry;
    end
  end

  // status to the controller
  always_comb begin
    st.req_read     = (operation == OP_READ);
    st.ptr_end      = (ptr == count);
    st.dec          = dec;
    st.merge_go     = (f > off) && sib[f];
    st.ev_split     = split && (ptr == CNT_W'(c_idx));
    st.ev_ins_first = is_add && !ins && (e_a > rp);
    st.up_end       = (k == req_l);
    st.dn_end       = (k == m + 8'd1);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fam     <= 1'b0;
      bank    <= 1'b0;
      count   <= '0;
      s_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        fam   <= cfg_data;
        count <= '0;
      end
      if (cmd.capture) s_valid <= 1'b0;
      if (cmd.scan_step) s_valid <= (ptr < count);
      if (cmd.copy_end) begin
        count <= wr_ptr + CNT_W'(we);
        bank  <= ~bank;
      end
    end
  end

  // request, pointers, scan results and results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= operation;
      req_a      <= in_a;
      req_l      <= in_len;
      off        <= in_off;
      f          <= in_len;
      req_idx    <= entry_index;
      ptr        <= (operation == OP_READ) ? CNT_W'(entry_index) : '0;
      cov        <= 1'b0;
      any_in     <= 1'b0;
      c_found    <= 1'b0;
      hit        <= 1'b0;
      sib        <= '0;
      res_found  <= '0;
      rd_entry   <= '0;
    end
    // scan pipeline
    if (cmd.scan_step && (ptr < count)) begin
      ptr   <= ptr + CNT_W'(1);
      s_idx <= ptr[IDX_W-1:0];
    end
    if (s_valid) begin
      if (e_cov) cov <= 1'b1;
      if (e_cov && !c_found) begin
        c_found <= 1'b1;
        c_idx   <= s_idx;
        m       <= e_l;
      end
      if (e_in) any_in <= 1'b1;
      if (e_hit && !hit) begin
        hit     <= 1'b1;
        hit_idx <= s_idx;
      end
      if (e_sib) sib[e_l] <= 1'b1;
    end
    if (cmd.decide) begin
      res_status <= dec_status;
      res_found  <= ((req_op == OP_CONTAINS || req_op == OP_INTERSECT) && hit) ?
                    8'(hit_idx) : '0;
      ptr        <= '0;
      wr_ptr     <= '0;
      ins        <= 1'b0;
    end
    if (cmd.merge_step) f <= f - 8'd1;
    // copy and split writers
    if (cmd.write_new) begin
      wr_ptr <= wr_ptr + CNT_W'(1);
      ins    <= 1'b1;
    end
    if (cmd.take) begin
      wr_ptr <= wr_ptr + CNT_W'(we);
      ptr    <= ptr + CNT_W'(1);
    end
    if (cmd.split_init) k <= m + 8'd1;
    if (cmd.split_up) begin
      wr_ptr <= wr_ptr + CNT_W'(we);
      if (k != req_l) k <= k + 8'd1;
    end
    if (cmd.split_dn) begin
      wr_ptr <= wr_ptr + CNT_W'(we);
      if (k == m + 8'd1) ptr <= ptr + CNT_W'(1);
      else k <= k - 8'd1;
    end
    // read entry
    if (cmd.read_latch) begin
      if (32'(req_idx) < 32'(count)) begin
        res_status <= ST_READ;
        rd_entry   <= rdata;
      end else begin
        res_status <= ST_MISS;
        rd_entry   <= '0;
      end
    end
  end

  assign status             = res_status;
  assign found_index        = res_found;
  assign entry_count        = 9'(count);
  assign read_address_high  = rd_entry[ENTRY_W-1:ENTRY_W-HALF_W];
  assign read_address_low   = rd_entry[ENTRY_W-HALF_W-1:LEN_W];
  assign read_prefix_length = rd_entry[LEN_W-1:0];

endmodule

// ===== dv/tb_cidr_prefix_set_table_unit.sv =====
// self-checking testbench for cidr_prefix_set_table_unit: directed and random
// commands, an in-bench prefix table predictor, a scoreboard on every result
// depends on cpst_pkg and the rtl of the block only
module tb_cidr_prefix_set_table_unit;
  import cpst_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] ah;
    logic [63:0] al;
    logic [7:0]  plen;
    logic [7:0]  idx;
  } cmd_item_t;

  typedef struct {
    logic [2:0]  st;
    logic [7:0]  fi;
    logic [8:0]  cnt;
    logic [63:0] rh;
    logic [63:0] rl;
    logic [7:0]  rlen;
  } table_result_t;

  logic        clk, rst, start, busy, done;
  logic [2:0]  operation;
  logic [63:0] address_high, address_low;
  logic [7:0]  prefix_length, entry_index;
  logic [2:0]  status;
  logic [7:0]  found_index;
  logic [8:0]  entry_count;
  logic [63:0] read_address_high, read_address_low;
  logic [7:0]  read_prefix_length;
  logic        cfg_valid, cfg_ready, cfg_data;

  cidr_prefix_set_table_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .address_high(address_high), .address_low(address_low),
    .prefix_length(prefix_length), .entry_index(entry_index),
    .done(done), .status(status), .found_index(found_index),
    .entry_count(entry_count), .read_address_high(read_address_high),
    .read_address_low(read_address_low), .read_prefix_length(read_prefix_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: full 128-bit first addresses, lengths stored without offset
  logic [127:0] pfx_addr [TABLE_DEPTH];
  int           pfx_len  [TABLE_DEPTH];
  int           pfx_count;
  bit           family;

  cmd_item_t     cmd_q[$];
  table_result_t expected_q[$];
  int            errors, n_accepted, n_checked, n_full, n_split;
  int            status_seen [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [127:0] lead_mask(int l);
    return (l == 0) ? 128'd0 : ({128{1'b1}} << (128 - l));
  endfunction

  function automatic logic [127:0] last_bit(int l);
    return 128'd1 << (128 - l);
  endfunction

  function automatic int len_off();
    return family ? 0 : 96;
  endfunction

  function automatic int full_len(int i);
    return pfx_len[i] + len_off();
  endfunction

  function automatic bit entry_covers(int i, logic [127:0] a, int l);
    return full_len(i) <= l && (a & lead_mask(full_len(i))) == pfx_addr[i];
  endfunction

  function automatic bit entry_under(int i, logic [127:0] a, int l);
    return full_len(i) >= l && (pfx_addr[i] & lead_mask(l)) == a;
  endfunction

  function automatic void drop_entry(int i);
    for (int j = i; j < pfx_count - 1; j++) begin
      pfx_addr[j] = pfx_addr[j+1];
      pfx_len[j]  = pfx_len[j+1];
    end
    pfx_count--;
  endfunction

  function automatic void place_entry(logic [127:0] a, int l);
    int j;
    j = 0;
    while (j < pfx_count && pfx_addr[j] < a) j++;
    for (int k = pfx_count; k > j; k--) begin
      pfx_addr[k] = pfx_addr[k-1];
      pfx_len[k]  = pfx_len[k-1];
    end
    pfx_addr[j] = a;
    pfx_len[j]  = l - len_off();
    pfx_count++;
  endfunction

  function automatic int sibling_at(logic [127:0] a, int l);
    for (int i = 0; i < pfx_count; i++)
      if (full_len(i) == l && pfx_addr[i] == (a ^ last_bit(l))) return i;
    return pfx_count;
  endfunction

  // apply one command to the predicted table and build its result
  function automatic table_result_t table_update(cmd_item_t it);
    table_result_t r;
    logic [127:0] a;
    int l, o, maxl, i, s, c, m, inner;
    bit cov;
    r = '{st: ST_MISS, fi: 8'd0, cnt: 9'd0, rh: 64'd0, rl: 64'd0, rlen: 8'd0};
    o = len_off();
    maxl = family ? 128 : 32;
    l = it.plen;
    if (l > maxl) l = maxl;
    l += o;
    a = family ? {it.ah, it.al} : {96'd0, it.al[31:0]};
    a &= lead_mask(l);
    case (it.op)
      OP_ADD: begin
        cov = 0;
        inner = 0;
        for (i = 0; i < pfx_count; i++) begin
          if (entry_covers(i, a, l)) cov = 1;
          if (entry_under(i, a, l)) inner++;
        end
        if (cov) begin
          r.st = ST_COVERED;
        end else if (inner == 0 && pfx_count >= TABLE_DEPTH &&
                     (l <= o || sibling_at(a, l) == pfx_count)) begin
          r.st = ST_FULL;
        end else begin
          i = 0;
          while (i < pfx_count) begin
            if (entry_under(i, a, l)) drop_entry(i);
            else i++;
          end
          // fold sibling pairs into their parent
          while (l > o) begin
            s = sibling_at(a, l);
            if (s >= pfx_count) break;
            drop_entry(s);
            l--;
            a &= lead_mask(l);
          end
          place_entry(a, l);
          r.st = ST_INSERTED;
        end
      end
      OP_REMOVE: begin
        c = pfx_count;
        for (i = 0; i < pfx_count; i++)
          if (entry_covers(i, a, l)) begin
            c = i;
            break;
          end
        if (c < pfx_count && full_len(c) < l) begin
          m = full_len(c);
          if (pfx_count + (l - m - 1) > TABLE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            // split the covering entry into the complement
            drop_entry(c);
            for (int k = m + 1; k <= l; k++)
              place_entry((a & lead_mask(k)) ^ last_bit(k), k);
            r.st = ST_REMOVED;
            n_split++;
          end
        end else begin
          r.st = ST_NONE;
          i = 0;
          while (i < pfx_count) begin
            if (entry_under(i, a, l)) begin
              drop_entry(i);
              r.st = ST_REMOVED;
            end else i++;
          end
        end
      end
      OP_CONTAINS, OP_INTERSECT: begin
        for (i = 0; i < pfx_count; i++)
          if (entry_covers(i, a, l) || (it.op == OP_INTERSECT && entry_under(i, a, l))) begin
            r.st = ST_HIT;
            r.fi = i[7:0];
            break;
          end
      end
      OP_READ: begin
        if (int'(it.idx) < pfx_count) begin
          r.st   = ST_READ;
          r.rh   = pfx_addr[it.idx][127:64];
          r.rl   = pfx_addr[it.idx][63:0];
          r.rlen = pfx_len[it.idx][7:0];
        end
      end
      default: ;
    endcase
    r.cnt = pfx_count[8:0];
    return r;
  endfunction

  function automatic cmd_item_t mk(logic [2:0] op, logic [63:0] ah, logic [63:0] al,
                                   logic [7:0] plen, logic [7:0] idx);
    mk = '{op: op, ah: ah, al: al, plen: plen, idx: idx};
  endfunction

  // random command: mostly clustered prefixes so that entries interact
  function automatic cmd_item_t rand_item(bit fam);
    cmd_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) it.op = OP_ADD;
    else if (pick < 60) it.op = OP_REMOVE;
    else if (pick < 72) it.op = OP_CONTAINS;
    else if (pick < 84) it.op = OP_INTERSECT;
    else if (pick < 96) it.op = OP_READ;
    else it.op = 3'($urandom_range(5, 7));
    it.idx = 8'($urandom_range(0, 47));
    if ($urandom_range(0, 9) == 0) begin
      // noise
      it.ah   = {$urandom, $urandom};
      it.al   = {$urandom, $urandom};
      it.plen = 8'($urandom);
      it.idx  = 8'($urandom);
      it.op   = 3'($urandom);
    end else if (!fam) begin
      it.ah   = {$urandom, $urandom};
      it.al   = {$urandom, 8'd10, 6'd0, 2'($urandom), 16'($urandom)};
      it.plen = 8'($urandom_range(14, 32));
    end else begin
      it.ah   = {56'h2001_0db8_0000_00, 6'd0, 2'($urandom)};
      it.al   = {$urandom, $urandom};
      it.plen = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 128))
                                            : 8'($urandom_range(62, 74));
    end
    return it;
  endfunction

  // driver: one command transaction at a time, random gaps and bursts
  int gap, burst_left;
  always @(posedge clk) begin
    cmd_item_t it;
    logic nxt_start;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
      burst_left = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        it = mk(operation, address_high, address_low, prefix_length, entry_index);
        expected_q.push_back(table_update(it));
        n_accepted++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap > 0) begin
          gap--;
        end else if (cmd_q.size() > 0) begin
          it = cmd_q.pop_front();
          operation     <= it.op;
          address_high  <= it.ah;
          address_low   <= it.al;
          prefix_length <= it.plen;
          entry_index   <= it.idx;
          nxt_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap = 0;
          end else if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
          end else begin
            gap = $urandom_range(0, 19);
            gap = (gap < 12) ? 0 : (gap < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          end
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    table_result_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding: status %0d", status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        status_seen[e.st]++;
        if (e.st == ST_FULL) n_full++;
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status);
          errors++;
        end
        if (found_index !== e.fi) begin
          $error("found_index exp %0d got %0d", e.fi, found_index);
          errors++;
        end
        if (entry_count !== e.cnt) begin
          $error("entry_count exp %0d got %0d", e.cnt, entry_count);
          errors++;
        end
        if (read_address_high !== e.rh) begin
          $error("read_address_high exp %h got %h", e.rh, read_address_high);
          errors++;
        end
        if (read_address_low !== e.rl) begin
          $error("read_address_low exp %h got %h", e.rl, read_address_low);
          errors++;
        end
        if (read_prefix_length !== e.rlen) begin
          $error("read_prefix_length exp %0d got %0d", e.rlen, read_prefix_length);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_cidr_prefix_set_table_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // wait until the block has drained every command
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || expected_q.size() != 0 || start);
  endtask

  // family write between phases; it empties the table
  task automatic set_family(bit fam);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fam;
    do @(posedge clk);
    while (!cfg_ready);
    family = fam;
    pfx_count = 0;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(bit fam, int n);
    set_family(fam);
    repeat (n) cmd_q.push_back(rand_item(fam));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ADD;
    address_high = '0;
    address_low = '0;
    prefix_length = '0;
    entry_index = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    family = 1'b0;
    pfx_count = 0;
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    n_full = 0;
    n_split = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, IPv4 after reset
    cmd_q.push_back(mk(OP_ADD,       64'd0, 64'h0A00_0000, 8'd8,  8'd0));
    cmd_q.push_back(mk(OP_ADD,       64'd0, 64'h0A01_0000, 8'd16, 8'd0));
    cmd_q.push_back(mk(OP_CONTAINS,  64'd0, 64'h0A01_0203, 8'd32, 8'd0));
    cmd_q.push_back(mk(OP_INTERSECT, 64'd0, 64'd0,         8'd0,  8'd0));
    cmd_q.push_back(mk(OP_READ,      64'd0, 64'd0,         8'd0,  8'd0));
    cmd_q.push_back(mk(OP_READ,      64'd0, 64'd0,         8'd0,  8'd5));
    cmd_q.push_back(mk(OP_REMOVE,    64'd0, 64'h0A01_0000, 8'd16, 8'd0));
    cmd_q.push_back(mk(OP_READ,      64'd0, 64'd0,         8'd0,  8'd7));
    cmd_q.push_back(mk(OP_ADD,       64'd0, 64'h0A01_0000, 8'd16, 8'd0));
    cmd_q.push_back(mk(OP_ADD,       64'd0, 64'hC0A8_0000, 8'd24, 8'd0));
    cmd_q.push_back(mk(OP_ADD,       64'd0, 64'hC0A8_0100, 8'd24, 8'd0));
    cmd_q.push_back(mk(OP_READ,      64'd0, 64'd0,         8'd0,  8'd1));
    cmd_q.push_back(mk(OP_INTERSECT, 64'd0, 64'hC000_0000, 8'd4,  8'd0));
    cmd_q.push_back(mk(OP_REMOVE,    64'd0, 64'd0,         8'd0,  8'd0));
    cmd_q.push_back(mk(OP_REMOVE,    64'd0, 64'd0,         8'd0,  8'd0));
    // ignored upper bits, host bits and an oversize length
    cmd_q.push_back(mk(OP_ADD, {64{1'b1}}, {64{1'b1}}, 8'd255, 8'd255));
    cmd_q.push_back(mk(OP_READ, {64{1'b1}}, {64{1'b1}}, 8'd200, 8'd0));
    cmd_q.push_back(mk(OP_ADD, 64'd0, 64'd0, 8'd0, 8'd0));
    cmd_q.push_back(mk(3'd5, {64{1'b1}}, {64{1'b1}}, 8'd255, 8'd255));
    cmd_q.push_back(mk(3'd6, 64'd0, 64'd0, 8'd0, 8'd0));
    cmd_q.push_back(mk(3'd7, 64'd0, 64'd0, 8'd0, 8'd0));
    cmd_q.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd0, 8'd255));

    // directed, IPv6: whole space, then a host split into 128 entries
    set_family(1'b1);
    cmd_q.push_back(mk(OP_ADD, {64{1'b1}}, {64{1'b1}}, 8'd128, 8'd0));
    cmd_q.push_back(mk(OP_ADD, 64'h1234, 64'h5678, 8'd0, 8'd0));
    cmd_q.push_back(mk(OP_REMOVE, {64{1'b1}}, {64{1'b1}}, 8'd255, 8'd0));
    cmd_q.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd0, 8'd127));
    cmd_q.push_back(mk(OP_CONTAINS, {64{1'b1}}, 64'd0, 8'd128, 8'd0));
    cmd_q.push_back(mk(OP_ADD, {64{1'b1}}, {64{1'b1}}, 8'd128, 8'd0));

    // fill the table with unmergeable /126s, then hit the full cases
    set_family(1'b1);
    for (int i = 0; i < TABLE_DEPTH; i++)
      cmd_q.push_back(mk(OP_ADD, 64'hFFFF_0000_0000_0000, 64'(i * 8), 8'd126, 8'd0));
    cmd_q.push_back(mk(OP_ADD, 64'hFFFF_0000_0000_0000, 64'(TABLE_DEPTH * 8), 8'd126, 8'd0));
    cmd_q.push_back(mk(OP_REMOVE, 64'hFFFF_0000_0000_0000, 64'h10, 8'd128, 8'd0));
    cmd_q.push_back(mk(OP_ADD, 64'hFFFF_0000_0000_0000, 64'h14, 8'd126, 8'd0));
    cmd_q.push_back(mk(OP_READ, 64'd0, 64'd0, 8'd0, 8'd255));
    cmd_q.push_back(mk(OP_REMOVE, 64'hFFFF_0000_0000_0000, 64'h28, 8'd128, 8'd0));

    // random phases across both families
    random_phase(1'b0, 50);
    random_phase(1'b1, 50);
    random_phase(1'b1, 50);
    random_phase(1'b0, 50);
    random_phase(1'b1, 50);
    random_phase(1'b0, 50);

    drain();
    repeat (50) @(posedge clk);
    $display("ran %0d commands, checked %0d results over both families", n_accepted, n_checked);
    $display("inserted %0d covered %0d full %0d split %0d hit %0d read %0d",
             status_seen[ST_INSERTED], status_seen[ST_COVERED], n_full, n_split,
             status_seen[ST_HIT], status_seen[ST_READ]);
    if (errors == 0) begin
      $display("tb_cidr_prefix_set_table_unit OK");
    end else begin
      $display("tb_cidr_prefix_set_table_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== cidr_prefix_set_table_unit.f =====
rtl/cpst_pkg.sv
rtl/cpst_ram.sv
rtl/cpst_ctrl.sv
rtl/cpst_dp.sv
rtl/cidr_prefix_set_table_unit.sv
dv/tb_cidr_prefix_set_table_unit.sv
